[src/rvw_pkg.sv]
// Package for the rolling VWAP window block.
// Holds the payload types and fixed widths; no dependencies.
package rvw_pkg;

  localparam int unsigned CfgBits = 11;
  localparam int unsigned ValueBits = 32;

  typedef struct packed {
    logic        series_start;
    logic [23:0] high_price;
    logic [23:0] low_price;
    logic [23:0] close_price;
    logic [23:0] bar_volume;
  } bar_t;

  typedef struct packed {
    logic [31:0] vwap_value;
    logic        vwap_valid;
  } vwap_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;      // Capture the input beat and start the ring reads.
    logic update;    // Update sums, write the ring, and start the division.
    logic div_step;  // One restoring division step.
    logic emit;      // Load the output register.
  } rvw_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic div_done;
  } rvw_sts_t;

endpackage

[src/rvw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rvw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[src/rvw_ctrl.sv]
// Controller for the rolling VWAP window: sequences load, update, divide, emit.
// Depends on rvw_pkg.
module rvw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_full_i,
  input  logic              out_stall_i,
  output rvw_pkg::rvw_cmd_t cmd_o,
  input  rvw_pkg::rvw_sts_t sts_i
);
  import rvw_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StDivide,
    StEmit
  } state_e;

  state_e state_q;

  // The output register frees when empty or when its beat is taken.
  logic out_free;
  assign out_free = !out_full_i || !out_stall_i;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == StIdle) && in_valid_i;
    cmd_o.update = (state_q == StUpdate);
    cmd_o.div_step = (state_q == StDivide) && !sts_i.div_done;
    cmd_o.emit = (state_q == StEmit) && out_free;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StUpdate;
        end
        StUpdate: state_q <= StDivide;
        StDivide: begin
          if (sts_i.div_done) state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

[src/rvw_dp.sv]
// Datapath for the rolling VWAP window: rings, running sums, serial divider.
// Depends on rvw_pkg and rvw_ram.
module rvw_dp #(
  parameter int unsigned MaxWindow  = 1024,
  parameter int unsigned PriceBits  = 24,
  parameter int unsigned VolumeBits = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rvw_pkg::bar_t              bar_i,
  input  logic                       cfg_we_i,
  input  logic [rvw_pkg::CfgBits-1:0] cfg_wdata_i,
  input  rvw_pkg::rvw_cmd_t          cmd_i,
  output rvw_pkg::rvw_sts_t          sts_o,
  output logic                       out_full_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output rvw_pkg::vwap_t             out_o
);
  import rvw_pkg::*;

  localparam int unsigned PtrBits = $clog2(MaxWindow);
  localparam int unsigned LenBits = $clog2(MaxWindow + 1);
  localparam int unsigned ProdBits = PriceBits + 2 + VolumeBits;
  localparam int unsigned VsumBits = VolumeBits + LenBits;
  localparam int unsigned WsumBits = ProdBits + LenBits;
  localparam int unsigned DenBits = VsumBits + 2;
  localparam int unsigned NumBits = WsumBits + 8;
  localparam int unsigned CntBits = $clog2(NumBits + 1);
  localparam logic [LenBits-1:0] MaxLen = LenBits'(MaxWindow);

  // Window length register and its saturated form.
  logic [CfgBits-1:0] wlen_q;
  logic [LenBits-1:0] len;
  always_comb begin
    if (wlen_q == '0) len = LenBits'(1);
    else if (32'(wlen_q) > MaxWindow) len = MaxLen;
    else len = LenBits'(wlen_q);
  end

  // Captured bar fields, ring pointer, fill count and running sums.
  logic                  start_q;
  logic [PriceBits+1:0]  psum_q;
  logic [VolumeBits-1:0] vol_q;
  logic [PtrBits-1:0]    ptr_q;
  logic [LenBits-1:0]    fill_q;
  logic [WsumBits-1:0]   wsum_q;
  logic [VsumBits-1:0]   vsum_q;

  // Ring read address of the entry that leaves the window.
  logic [PtrBits:0] old_sum;
  logic [PtrBits-1:0] old_addr;
  always_comb begin
    old_sum = {1'b0, ptr_q} + (PtrBits+1)'(MaxWindow) - (PtrBits+1)'(len);
    if (old_sum >= (PtrBits+1)'(MaxWindow)) old_sum = old_sum - (PtrBits+1)'(MaxWindow);
    old_addr = old_sum[PtrBits-1:0];
  end

  logic [ProdBits-1:0]   prod;
  logic [ProdBits-1:0]   wold;
  logic [VolumeBits-1:0] vold;
  assign prod = ProdBits'(psum_q) * ProdBits'(vol_q);

  rvw_ram #(.Width(ProdBits), .Depth(MaxWindow)) u_wring (
    .clk_i, .we_i(cmd_i.update), .waddr_i(ptr_q), .wdata_i(prod),
    .raddr_i(old_addr), .rdata_o(wold)
  );
  rvw_ram #(.Width(VolumeBits), .Depth(MaxWindow)) u_vring (
    .clk_i, .we_i(cmd_i.update), .waddr_i(ptr_q), .wdata_i(vol_q),
    .raddr_i(old_addr), .rdata_o(vold)
  );

  // Next sums for this bar.
  logic [LenBits-1:0]  fill_base;
  logic [WsumBits-1:0] wbase;
  logic [VsumBits-1:0] vbase;
  logic [WsumBits-1:0] wsum_d;
  logic [VsumBits-1:0] vsum_d;
  logic [LenBits-1:0]  fill_d;
  logic                drop;
  always_comb begin
    fill_base = start_q ? '0 : fill_q;
    wbase = start_q ? '0 : wsum_q;
    vbase = start_q ? '0 : vsum_q;
    drop = (fill_base >= len);
    wsum_d = wbase + WsumBits'(prod) - (drop ? WsumBits'(wold) : '0);
    vsum_d = vbase + VsumBits'(vol_q) - (drop ? VsumBits'(vold) : '0);
    fill_d = drop ? fill_base : fill_base + LenBits'(1);
  end

  // Restoring divider state.
  logic [NumBits-1:0] num_q;
  logic [DenBits-1:0] den_q;
  logic [DenBits:0]   rem_q;
  logic [CntBits-1:0] cnt_q;
  logic               ok_q;
  logic [DenBits:0]   rem_sh;
  always_comb begin
    rem_sh = {rem_q[DenBits-1:0], num_q[NumBits-1]};
  end
  assign sts_o.div_done = (cnt_q == '0);

  // Sequential state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= CfgBits'(200);
      ptr_q <= '0;
      fill_q <= '0;
      wsum_q <= '0;
      vsum_q <= '0;
      cnt_q <= '0;
      out_full_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
        fill_q <= '0;
        wsum_q <= '0;
        vsum_q <= '0;
      end
      if (cmd_i.update) begin
        wsum_q <= wsum_d;
        vsum_q <= vsum_d;
        fill_q <= fill_d;
        ptr_q <= (ptr_q == PtrBits'(MaxWindow - 1)) ? '0 : ptr_q + PtrBits'(1);
        cnt_q <= CntBits'(NumBits);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
      if (cmd_i.emit) out_full_o <= 1'b1;
      else if (!out_stall_i) out_full_o <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= bar_i.series_start;
      psum_q <= (PriceBits+2)'(bar_i.high_price[PriceBits-1:0]) +
                (PriceBits+2)'(bar_i.low_price[PriceBits-1:0]) +
                (PriceBits+2)'(bar_i.close_price[PriceBits-1:0]);
      vol_q <= bar_i.bar_volume[VolumeBits-1:0];
    end
    if (cmd_i.update) begin
      num_q <= {wsum_d, 8'h00};
      den_q <= DenBits'(vsum_d) + {vsum_d, 1'b0};
      rem_q <= '0;
      ok_q <= (fill_d >= len) && (vsum_d != '0);
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        num_q <= {num_q[NumBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[NumBits-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      out_o.vwap_value <= ok_q ? num_q[ValueBits-1:0] : '0;
      out_o.vwap_valid <= ok_q;
    end
  end

  assign out_valid_o = out_full_o;
endmodule

[src/rolling_vwap_window.sv]
// Top level of the rolling VWAP window block.
// Depends on rvw_pkg, rvw_ctrl, rvw_dp and rvw_ram.
//
// Each bar beat yields one result beat. The quotient comes from a
// one-bit-per-cycle restoring divider, and the block holds one bar at a time.
// Writing window_length clears the sums and the fill count. The result
// sits in an output register, so the next bar is taken while it waits.
module rolling_vwap_window #(
  parameter int unsigned MAX_WINDOW  = 1024,
  parameter int unsigned PRICE_BITS  = 24,
  parameter int unsigned VOLUME_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rvw_pkg::bar_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rvw_pkg::vwap_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic [rvw_pkg::CfgBits-1:0] cfg_wdata_i
);
  import rvw_pkg::*;

  rvw_cmd_t cmd;
  rvw_sts_t sts;
  logic     out_full;

  rvw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_full_i(out_full), .out_stall_i, .cmd_o(cmd), .sts_i(sts)
  );

  rvw_dp #(
    .MaxWindow(MAX_WINDOW), .PriceBits(PRICE_BITS), .VolumeBits(VOLUME_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .bar_i(in_data_i), .cfg_we_i, .cfg_wdata_i,
    .cmd_i(cmd), .sts_o(sts), .out_full_o(out_full), .out_stall_i,
    .out_valid_o, .out_o(out_data_o)
  );
endmodule

[src/rvw_checker.sv]
// Port-level checker for the rolling VWAP window, bound to the top level.
// Depends on rvw_pkg.
module rvw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rvw_pkg::vwap_t out_data_o
);
  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // A beat accepted makes the block busy next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after accept");

  // An invalid average reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.vwap_valid |-> out_data_o.vwap_value == '0)
    else $error("invalid result carries a value");

  // No result appears right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early");
endmodule

bind rolling_vwap_window rvw_checker u_rvw_checker (.*);

[verif/tb_rolling_vwap_window.sv]
// Testbench for rolling_vwap_window: random and directed bars against a predictor.
// Depends on rvw_pkg and the rolling_vwap_window RTL.
`timescale 1ns / 100ps

module tb_rolling_vwap_window;
  import rvw_pkg::*;

  localparam int unsigned RingDepth = 1024;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned LongHold = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bar_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  vwap_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgBits-1:0] cfg_wdata_i = '0;

  rolling_vwap_window dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state, kept apart from the design.
  logic [63:0] price_ring [RingDepth];
  logic [63:0] vol_ring [RingDepth];
  logic [63:0] pv_sum;
  logic [63:0] vol_sum;
  int unsigned wr_ptr;
  int unsigned bars_seen;
  int unsigned win_len;

  vwap_t pending_vwap [$];
  int unsigned mismatches = 0;
  int unsigned bars_sent = 0;
  int unsigned vwaps_checked = 0;
  int unsigned valid_vwaps = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cycles = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_taken = 0;

  // Advance the predictor by one bar and return the VWAP it produces.
  function automatic vwap_t predict_vwap(bar_t b);
    int unsigned len;
    int unsigned old;
    logic [63:0] prod;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    vwap_t r;
    len = (win_len == 0) ? 1 : ((win_len > RingDepth) ? RingDepth : win_len);
    prod = (64'(b.high_price) + 64'(b.low_price) + 64'(b.close_price)) * 64'(b.bar_volume);
    if (b.series_start) begin
      pv_sum = '0;
      vol_sum = '0;
      bars_seen = 0;
    end
    if (bars_seen >= len) begin
      old = (wr_ptr + RingDepth - len) % RingDepth;
      pv_sum -= price_ring[old];
      vol_sum -= vol_ring[old];
    end
    price_ring[wr_ptr] = prod;
    vol_ring[wr_ptr] = 64'(b.bar_volume);
    pv_sum += prod;
    vol_sum += 64'(b.bar_volume);
    wr_ptr = (wr_ptr + 1) % RingDepth;
    if (bars_seen < len) bars_seen++;
    r = '0;
    if (bars_seen >= len && vol_sum != 0) begin
      den = 3 * vol_sum;
      quo = pv_sum / den;
      rem = pv_sum % den;
      r.vwap_value = 32'((quo << 8) + ((rem << 8) / den));
      r.vwap_valid = 1'b1;
    end
    return r;
  endfunction

  // Predict on every accepted bar beat.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_vwap.insert(pending_vwap.size(), predict_vwap(in_data_i));
      bars_sent++;
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    vwap_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      vwaps_checked++;
      if (pending_vwap.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $display("Unexpected result beat: %h", out_data_o);
      end else begin
        want = pending_vwap.pop_front();
        if (out_data_o.vwap_valid) valid_vwaps++;
        if (out_data_o.vwap_value !== want.vwap_value ||
            out_data_o.vwap_valid !== want.vwap_valid) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("Mismatch: expected value %h valid %b, got value %h valid %b",
                     want.vwap_value, want.vwap_valid,
                     out_data_o.vwap_value, out_data_o.vwap_valid);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Random gap length: mostly zero, some short, a few long.
  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(4, 1);
    return $urandom_range(60, 10);
  endfunction

  // Receiver stall: a long hold when requested, otherwise random bursts.
  always @(negedge clk_i) begin
    if (hold_reqs != hold_taken) begin
      out_stall_i <= 1'b1;
      hold_taken <= hold_reqs;
      hold_cycles <= LongHold;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if ($urandom_range(99) < 15) begin
      out_stall_i <= 1'b1;
      hold_cycles <= rand_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Offer one bar beat and wait until it is taken.
  task automatic send_bar(bar_t b, bit with_gap);
    int unsigned gap;
    gap = with_gap ? rand_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop offering, then wait until every predicted result has arrived.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_vwap.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write window_length while the block is idle; the predictor restarts its series.
  task automatic set_window(int unsigned len);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CfgBits'(len);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    win_len = len & 11'h7FF;
    pv_sum = '0;
    vol_sum = '0;
    bars_seen = 0;
  endtask

  function automatic bar_t make_bar(bit start, int unsigned hi, int unsigned lo,
                                    int unsigned cl, int unsigned vol);
    bar_t b;
    b.series_start = start;
    b.high_price = 24'(hi);
    b.low_price = 24'(lo);
    b.close_price = 24'(cl);
    b.bar_volume = 24'(vol);
    return b;
  endfunction

  // Random bar: full-range fields with occasional extremes and zero volume.
  function automatic bar_t rand_bar();
    bar_t b;
    b.series_start = ($urandom_range(99) < 3);
    b.high_price = ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom);
    b.low_price = ($urandom_range(9) == 0) ? 24'h0 : 24'($urandom);
    b.close_price = 24'($urandom);
    case ($urandom_range(9))
      0, 1: b.bar_volume = 24'h0;
      2: b.bar_volume = 24'hFFFFFF;
      3: b.bar_volume = 24'($urandom_range(3));
      default: b.bar_volume = 24'($urandom);
    endcase
    return b;
  endfunction

  // Extremes, zero volume, series restarts and odd window lengths.
  task automatic test_directed();
    set_window(3);
    send_bar(make_bar(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 0);
    send_bar(make_bar(0, 0, 0, 0, 0), 0);
    send_bar(make_bar(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 0);
    send_bar(make_bar(0, 100, 90, 95, 7), 0);
    send_bar(make_bar(0, 1, 0, 0, 1), 0);
    send_bar(make_bar(1, 5, 4, 3, 0), 0);
    send_bar(make_bar(0, 5, 4, 3, 0), 0);
    send_bar(make_bar(0, 5, 4, 3, 0), 0);
    send_bar(make_bar(0, 24'hAAAAAA, 24'h555555, 24'h123456, 24'h000001), 0);
    // Window length zero behaves as a one-bar window.
    set_window(0);
    send_bar(make_bar(0, 10, 20, 30, 1), 0);
    send_bar(make_bar(0, 10, 20, 30, 0), 0);
    send_bar(make_bar(1, 24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF), 0);
    set_window(1024);
    for (int i = 0; i < 4; i++) send_bar(rand_bar(), 0);
    set_window(1);
    send_bar(make_bar(0, 24'h555555, 24'hAAAAAA, 24'hFFFFFF, 24'hABCDEF), 0);
    send_bar(make_bar(0, 0, 0, 1, 24'hFFFFFF), 0);
  endtask

  // Long receiver hold while bars keep coming, then a full drain.
  task automatic test_backpressure();
    set_window(4);
    @(negedge clk_i);
    hold_reqs++;
    for (int i = 0; i < 30; i++) send_bar(rand_bar(), 0);
    drain();
  endtask

  // Random bars over several window settings, ending with a saturated window.
  task automatic test_random();
    int unsigned lens [5] = '{1, 2, 5, 37, 2047};
    int unsigned counts [5] = '{100, 100, 120, 150, 1150};
    for (int s = 0; s < 5; s++) begin
      set_window(lens[s]);
      for (int i = 0; i < counts[s]; i++) send_bar(rand_bar(), $urandom_range(3) != 0);
    end
  endtask

  initial begin
    win_len = 200;
    pv_sum = '0;
    vol_sum = '0;
    wr_ptr = 0;
    bars_seen = 0;
    for (int i = 0; i < RingDepth; i++) begin
      price_ring[i] = '0;
      vol_ring[i] = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    drain();
    $display("Bars sent: %0d, results checked: %0d, of which valid: %0d, mismatches: %0d",
             bars_sent, vwaps_checked, valid_vwaps, mismatches);
    $display("Covered window lengths 0, 1..37, 1024 and saturated 2047 under backpressure.");
    if (mismatches == 0 && pending_vwap.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
